>>> sv/frsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frsd_pkg
// Shared widths, request and register codes, and the controller to datapath
// command and status words of the frame rms silence detector.
// ----------------------------------------------------------------------------
package frsd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 17;
  localparam int SQ_W       = 31;
  localparam int RMS_W      = 16;
  localparam int PEAK_W     = 15;
  localparam int CNT_OUT_W  = 11;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = 16;
  localparam int SQRT_STEPS = 16;
  localparam int SQRT_IDX_W = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_DISABLE = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RMS_THRESHOLD = 2'd0,
    CFG_SILENCE_LIMIT = 2'd1,
    CFG_MIN_SPEECH    = 2'd2,
    CFG_NONE          = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                  take_sample;
    logic                  det_on;
    logic                  det_off;
    logic                  accumulate;
    logic                  div_load;
    logic                  div_step;
    logic                  sqrt_clear;
    logic                  sqrt_step;
    logic [SQRT_IDX_W-1:0] sqrt_idx;
    logic                  write_result;
  } frsd_cmd_t;

  typedef struct packed {
    logic tally_full;
    logic out_free;
  } frsd_status_t;

endpackage
`default_nettype wire

>>> sv/frsd_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frsd interfaces
// Valid/ready channels for requests, frame results and register writes.
// ----------------------------------------------------------------------------
interface frsd_req_if import frsd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_last;

  modport source (output valid, output req_type, output sample, output frame_last,
                  input ready);
  modport sink   (input valid, input req_type, input sample, input frame_last,
                  output ready);
endinterface

interface frsd_res_if import frsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RMS_W-1:0]     frame_rms;
  logic [PEAK_W-1:0]    frame_peak;
  logic [CNT_OUT_W-1:0] frame_zeros;
  logic [CNT_OUT_W-1:0] frame_samples;
  logic                 stop_request;
  logic                 detector_active;

  modport source (output valid, output frame_rms, output frame_peak, output frame_zeros,
                  output frame_samples, output stop_request, output detector_active,
                  input ready);
  modport sink   (input valid, input frame_rms, input frame_peak, input frame_zeros,
                  input frame_samples, input stop_request, input detector_active,
                  output ready);
endinterface

interface frsd_cfg_if import frsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/frsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frsd_ctrl
// Sequencer: takes requests, then steps the divider and the square root unit
// at frame end and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module frsd_ctrl import frsd_pkg::*; #(
  parameter int SumW = 41
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [REQ_W-1:0] req_type_i,
  input  wire logic             frame_last_i,
  input  wire frsd_status_t     status_i,
  output frsd_cmd_t             cmd_o
);

  localparam int StepW = $clog2(SumW);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACC   = 5'b00010,
    S_DIV   = 5'b00100,
    S_SQRT  = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             frame_end_q, frame_end_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    frame_end_d = frame_end_q;
    cmd_o       = '0;
    in_ready_o  = (state_q == S_IDLE);
    cmd_o.sqrt_idx = step_q[SQRT_IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (req_type_i)
            REQ_SAMPLE: begin
              cmd_o.take_sample = 1'b1;
              frame_end_d       = frame_last_i || status_i.tally_full;
              state_d           = S_ACC;
            end
            REQ_ENABLE:  cmd_o.det_on  = 1'b1;
            REQ_DISABLE: cmd_o.det_off = 1'b1;
            default: ;
          endcase
        end
      end
      S_ACC: begin
        cmd_o.accumulate = 1'b1;
        if (frame_end_q) begin
          cmd_o.div_load = 1'b1;
          step_d         = '0;
          state_d        = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == StepW'(SumW - 1)) begin
          cmd_o.sqrt_clear = 1'b1;
          step_d           = '0;
          state_d          = S_SQRT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == StepW'(SQRT_STEPS - 1)) begin
          step_d  = '0;
          state_d = S_WRITE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write_result = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      frame_end_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      frame_end_q <= frame_end_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/frsd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frsd_datapath
// Frame accumulators, bit-serial divider, digit-by-digit square root,
// silence detector counters, config registers and the result register.
// ----------------------------------------------------------------------------
module frsd_datapath import frsd_pkg::*; #(
  parameter int MaxFrame   = 1024,
  parameter int CounterW   = 16,
  parameter int TallyW     = 11,
  parameter int SumW       = 41
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire frsd_cmd_t                  cmd_i,
  output frsd_status_t                    status_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [RMS_W-1:0]                out_rms_o,
  output logic [PEAK_W-1:0]               out_peak_o,
  output logic [CNT_OUT_W-1:0]            out_zeros_o,
  output logic [CNT_OUT_W-1:0]            out_samples_o,
  output logic                            out_stop_o,
  output logic                            out_active_o
);

  localparam int CmpW = (CounterW > CFG_DATA_W) ? CounterW : CFG_DATA_W;
  localparam logic [CounterW-1:0] CntMax = {CounterW{1'b1}};

  // config registers
  logic [CFG_DATA_W-1:0] thr_q, limit_q, min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      limit_q <= '0;
      min_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RMS_THRESHOLD: thr_q   <= cfg_data_i;
        CFG_SILENCE_LIMIT: limit_q <= cfg_data_i;
        CFG_MIN_SPEECH:    min_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame accumulators
  logic [SAMPLE_W-1:0]  raw;
  logic [MAG_W-1:0]     mag;
  logic [2*MAG_W-1:0]   sq_full;
  logic [SQ_W-1:0]      sq_q;
  logic [SumW-1:0]      sum_q;
  logic [TallyW-1:0]    tally_q, zeros_q;
  logic [PEAK_W-1:0]    peak_q;
  logic [SumW-1:0]      sum_next;

  assign raw      = sample_i;
  assign mag      = raw[SAMPLE_W-1] ? MAG_W'({1'b1, {SAMPLE_W{1'b0}}} - {1'b0, raw})
                                    : {1'b0, raw};
  assign sq_full  = mag * mag;
  assign sum_next = sum_q + SumW'(sq_q);

  assign status_o.tally_full = (tally_q >= TallyW'(MaxFrame - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_sample) begin
      sq_q <= sq_full[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      tally_q <= '0;
      zeros_q <= '0;
      peak_q  <= '0;
    end else if (cmd_i.write_result) begin
      sum_q   <= '0;
      tally_q <= '0;
      zeros_q <= '0;
      peak_q  <= '0;
    end else if (cmd_i.take_sample) begin
      tally_q <= tally_q + 1'b1;
      if (raw == '0) begin
        zeros_q <= zeros_q + 1'b1;
      end
      if (mag[MAG_W-1:PEAK_W] == '0 && mag[PEAK_W-1:0] > peak_q) begin
        peak_q <= mag[PEAK_W-1:0];
      end
    end else if (cmd_i.accumulate) begin
      sum_q <= sum_next;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [SumW-1:0]   div_q;
  logic [TallyW-1:0] rem_q;
  logic [TallyW:0]   rem_sh;
  logic              div_ge;

  assign rem_sh = {rem_q, div_q[SumW-1]};
  assign div_ge = (rem_sh >= {1'b0, tally_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      div_q <= sum_next;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q <= {div_q[SumW-2:0], div_ge};
      rem_q <= div_ge ? TallyW'(rem_sh - {1'b0, tally_q}) : TallyW'(rem_sh);
    end
  end

  // square root, one root bit per cycle
  logic [RAD_W-1:0]    rad;
  logic [1:0]          pair;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W+1:0]   srem_q;
  logic [ROOT_W+3:0]   srem_sh, trial;
  logic                sqrt_ge;

  assign rad     = RAD_W'(div_q);
  assign pair    = rad[RAD_W - 1 - 2 * int'(cmd_i.sqrt_idx) -: 2];
  assign srem_sh = {srem_q, pair};
  assign trial   = {2'b00, root_q, 2'b01};
  assign sqrt_ge = (srem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_clear) begin
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      root_q <= {root_q[ROOT_W-2:0], sqrt_ge};
      srem_q <= sqrt_ge ? (ROOT_W+2)'(srem_sh - trial) : (ROOT_W+2)'(srem_sh);
    end
  end

  // silence detector
  logic [CounterW-1:0] silent_q, speech_q, silent_inc, speech_inc;
  logic                enabled_q;
  logic                is_silent, det_live, stop;

  assign silent_inc = (silent_q == CntMax) ? silent_q : silent_q + 1'b1;
  assign speech_inc = (speech_q == CntMax) ? speech_q : speech_q + 1'b1;
  assign is_silent  = (root_q < thr_q);
  assign det_live   = enabled_q && (limit_q != '0);
  assign stop       = det_live && is_silent
                      && (CmpW'(silent_inc) >= CmpW'(limit_q))
                      && (CmpW'(speech_q) >= CmpW'(min_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silent_q  <= '0;
      speech_q  <= '0;
      enabled_q <= 1'b0;
    end else if (cmd_i.det_on) begin
      silent_q  <= '0;
      speech_q  <= '0;
      enabled_q <= 1'b1;
    end else if (cmd_i.det_off) begin
      enabled_q <= 1'b0;
    end else if (cmd_i.write_result && det_live) begin
      if (is_silent) begin
        silent_q <= silent_inc;
        if (stop) begin
          enabled_q <= 1'b0;
        end
      end else begin
        silent_q <= '0;
        speech_q <= speech_inc;
      end
    end
  end

  // result register
  assign status_o.out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.write_result) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_result) begin
      out_rms_o     <= root_q;
      out_peak_o    <= peak_q;
      out_zeros_o   <= CNT_OUT_W'(zeros_q);
      out_samples_o <= CNT_OUT_W'(tally_q);
      out_stop_o    <= stop;
      out_active_o  <= enabled_q;
    end
  end

endmodule
`default_nettype wire

>>> sv/frame_rms_silence_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_rms_silence_detector_core
// Energy based voice activity detector: per-frame rms, peak and zero count,
// with a silence timeout that raises a stop request.
// ----------------------------------------------------------------------------
// a sample is accepted, then its square is accumulated; commands are taken on acceptance
// a frame-ending sample holds the input through accumulate, divide, square root and
// write, which waits for a free result register; SUM_W = 30 + clog2(MAX_FRAME_SAMPLES + 1)
// the divide is bit-serial (SUM_W steps), the square root digit-wise (16 steps)
// the result register lets the next frame start while a result waits
// rst_ni clears all config registers, accumulators and counters; detector off
module frame_rms_silence_detector_core import frsd_pkg::*; #(
  parameter int MAX_FRAME_SAMPLES = 1024,
  parameter int COUNTER_BITS      = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  frsd_req_if.sink    req_i,
  frsd_res_if.source  res_o,
  frsd_cfg_if.sink    cfg_i
);

  localparam int TallyW = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SumW   = 30 + TallyW;

  frsd_cmd_t    cmd;
  frsd_status_t status;

  assign cfg_i.ready = 1'b1;

  frsd_ctrl #(
    .SumW (SumW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_ready_o   (req_i.ready),
    .req_type_i   (req_i.req_type),
    .frame_last_i (req_i.frame_last),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  frsd_datapath #(
    .MaxFrame (MAX_FRAME_SAMPLES),
    .CounterW (COUNTER_BITS),
    .TallyW   (TallyW),
    .SumW     (SumW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (req_i.sample),
    .cfg_we_i      (cfg_i.valid),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .out_rms_o     (res_o.frame_rms),
    .out_peak_o    (res_o.frame_peak),
    .out_zeros_o   (res_o.frame_zeros),
    .out_samples_o (res_o.frame_samples),
    .out_stop_o    (res_o.stop_request),
    .out_active_o  (res_o.detector_active)
  );

endmodule
`default_nettype wire

>>> sv/frsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frsd_checker
// Port-level checks of the detector core, bound onto the top level.
// ----------------------------------------------------------------------------
module frsd_checker import frsd_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire logic [REQ_W-1:0]     in_req_type_i,
  input wire logic                 in_frame_last_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [RMS_W-1:0]     out_rms_i,
  input wire logic [PEAK_W-1:0]    out_peak_i,
  input wire logic [CNT_OUT_W-1:0] out_zeros_i,
  input wire logic [CNT_OUT_W-1:0] out_samples_i,
  input wire logic                 out_stop_i,
  input wire logic                 out_active_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a word that is held back stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // a sample flagged frame_last is followed by a busy input while the frame is reduced
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_req_type_i == REQ_SAMPLE && in_frame_last_i |=> !in_ready_i)
    else $error("input taken during frame reduction");

  // any accepted sample is followed by the accumulate step, with the input busy
  a_sample_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_req_type_i == REQ_SAMPLE |=> !in_ready_i)
    else $error("sample accepted back to back");

  // a stop can only come from an active detector
  a_stop_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stop_i |-> out_active_i)
    else $error("stop request without active detector");

  // a stalled word does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_rms_i) && $stable(out_peak_i)
      && $stable(out_zeros_i) && $stable(out_samples_i) && $stable(out_stop_i)
      && $stable(out_active_i))
    else $error("result word changed while stalled");

endmodule

bind frame_rms_silence_detector_core frsd_checker u_frsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .in_req_type_i   (req_i.req_type),
  .in_frame_last_i (req_i.frame_last),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .out_rms_i       (res_o.frame_rms),
  .out_peak_i      (res_o.frame_peak),
  .out_zeros_i     (res_o.frame_zeros),
  .out_samples_i   (res_o.frame_samples),
  .out_stop_i      (res_o.stop_request),
  .out_active_i    (res_o.detector_active)
);
`default_nettype wire
